### rtl/bdeq_pkg.sv
// Shared constants and types for the bounded double-ended queue.
package bdeq_pkg;

    // Ring storage depth; must be a power of two, at least 2.
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CAP_W = 11;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int VAL_W = 32;
    localparam int REQ_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);
    localparam logic [VAL_W-1:0] EMPTY_VALUE = {VAL_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DONE = 2'b10
    } bdeq_state_t;

endpackage

### rtl/bdeq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bounded_double_ended_queue_unit.sv
// Bounded double-ended queue on a ring held in a synchronous RAM.
//
//   Channel   Handshake               Payload
//   in        in_valid / in_stall     req_type, value
//   out       out_valid / out_stall   ok, front_value, rear_value, is_empty, is_full
//   cfg       cfg_valid / cfg_ready   cfg_data (capacity)
//
// Every request passes through ST_IDLE and ST_DONE: the accept in ST_IDLE updates the pointers,
// count and cached end values and issues the RAM write or read; ST_DONE picks up the
// registered RAM read data and hands the result to the output register.
// A request can be accepted while the previous result waits in the output register;
// it then holds in ST_DONE, and further requests stall until that result
// is taken.
// Reset empties the queue and sets capacity to 1024; the RAM is not cleared.
module bounded_double_ended_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bdeq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [bdeq_pkg::VAL_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic signed [bdeq_pkg::VAL_W-1:0]  front_value,
    output logic signed [bdeq_pkg::VAL_W-1:0]  rear_value,
    output logic                               is_empty,
    output logic                               is_full,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdeq_pkg::CAP_W-1:0]         cfg_data
);

    import bdeq_pkg::*;

    bdeq_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  front_idx_reg, front_idx_next;
    logic [VAL_W-1:0]  front_cache_reg, front_cache_next;
    logic [VAL_W-1:0]  rear_cache_reg, rear_cache_next;
    logic              ok_pend_reg, ok_pend_next;
    logic              rd_front_reg, rd_front_next;
    logic              rd_rear_reg, rd_rear_next;
    logic [CAP_W-1:0]  capacity_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]  out_front_reg, out_front_next;
    logic [VAL_W-1:0]  out_rear_reg, out_rear_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_full_reg, out_full_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [VAL_W-1:0]  rd_data;

    logic              in_fire;
    logic              out_load;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;
    logic              q_full;
    logic              q_empty;
    logic [IDX_W-1:0]  count_lo;
    logic [VAL_W-1:0]  front_view;
    logic [VAL_W-1:0]  rear_view;

    bdeq_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(value),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // A capacity above the ring depth saturates at the depth.
    assign cap_ext  = CMP_W'(capacity_reg);
    assign eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign q_full   = CMP_W'(count_reg) >= eff_cap;
    assign q_empty  = (count_reg == '0);
    assign count_lo = count_reg[IDX_W-1:0];

    assign in_fire  = in_valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // The RAM read of a removal lands in the cycle after the accept.
    assign front_view = rd_front_reg ? rd_data : front_cache_reg;
    assign rear_view  = rd_rear_reg  ? rd_data : rear_cache_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        front_idx_next   = front_idx_reg;
        front_cache_next = front_cache_reg;
        rear_cache_next  = rear_cache_reg;
        ok_pend_next     = ok_pend_reg;
        rd_front_next    = rd_front_reg;
        rd_rear_next     = rd_rear_reg;
        wr_en            = 1'b0;
        wr_addr          = front_idx_reg;
        rd_en            = 1'b0;
        rd_addr          = front_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next    = ST_DONE;
                    ok_pend_next  = 1'b0;
                    rd_front_next = 1'b0;
                    rd_rear_next  = 1'b0;
                    case (req_type)
                        REQ_INS_FRONT:
                        begin
                            if (!q_full)
                            begin
                                front_idx_next   = front_idx_reg - IDX_W'(1);
                                wr_en            = 1'b1;
                                wr_addr          = front_idx_reg - IDX_W'(1);
                                count_next       = count_reg + CNT_W'(1);
                                front_cache_next = value;
                                if (q_empty)
                                begin
                                    rear_cache_next = value;
                                end
                                ok_pend_next     = 1'b1;
                            end
                        end
                        REQ_INS_BACK:
                        begin
                            if (!q_full)
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = front_idx_reg + count_lo;
                                count_next      = count_reg + CNT_W'(1);
                                rear_cache_next = value;
                                if (q_empty)
                                begin
                                    front_cache_next = value;
                                end
                                ok_pend_next    = 1'b1;
                            end
                        end
                        REQ_DEL_FRONT:
                        begin
                            if (!q_empty)
                            begin
                                front_idx_next = front_idx_reg + IDX_W'(1);
                                count_next     = count_reg - CNT_W'(1);
                                ok_pend_next   = 1'b1;
                                // Fetch the new front unless the queue drains.
                                if (count_reg != CNT_W'(1))
                                begin
                                    rd_en         = 1'b1;
                                    rd_addr       = front_idx_reg + IDX_W'(1);
                                    rd_front_next = 1'b1;
                                end
                            end
                        end
                        REQ_DEL_BACK:
                        begin
                            if (!q_empty)
                            begin
                                count_next   = count_reg - CNT_W'(1);
                                ok_pend_next = 1'b1;
                                if (count_reg != CNT_W'(1))
                                begin
                                    rd_en        = 1'b1;
                                    rd_addr      = front_idx_reg + count_lo - IDX_W'(2);
                                    rd_rear_next = 1'b1;
                                end
                            end
                        end
                        REQ_STATUS:
                        begin
                            ok_pend_next = 1'b1;
                        end
                        default:
                        begin
                            ok_pend_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next       = ST_IDLE;
                    front_cache_next = front_view;
                    rear_cache_next  = rear_view;
                    rd_front_next    = 1'b0;
                    rd_rear_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_front_next = out_front_reg;
        out_rear_next  = out_rear_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = ok_pend_reg;
            out_front_next = q_empty ? EMPTY_VALUE : front_view;
            out_rear_next  = q_empty ? EMPTY_VALUE : rear_view;
            out_empty_next = q_empty;
            out_full_next  = q_full;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            front_idx_reg <= '0;
            ok_pend_reg   <= 1'b0;
            rd_front_reg  <= 1'b0;
            rd_rear_reg   <= 1'b0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_idx_reg <= front_idx_next;
            ok_pend_reg   <= ok_pend_next;
            rd_front_reg  <= rd_front_next;
            rd_rear_reg   <= rd_rear_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_cache_reg <= front_cache_next;
        rear_cache_reg  <= rear_cache_next;
        out_ok_reg      <= out_ok_next;
        out_front_reg   <= out_front_next;
        out_rear_reg    <= out_rear_next;
        out_empty_reg   <= out_empty_next;
        out_full_reg    <= out_full_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign front_value = out_front_reg;
    assign rear_value  = out_rear_reg;
    assign is_empty    = out_empty_reg;
    assign is_full     = out_full_reg;

endmodule

### rtl/bdeq_checker.sv
// Port-level checks for the bounded double-ended queue, bound to the top level.
module bdeq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               ok,
    input logic signed [bdeq_pkg::VAL_W-1:0]  front_value,
    input logic signed [bdeq_pkg::VAL_W-1:0]  rear_value,
    input logic                               is_empty
);

    import bdeq_pkg::*;

    // A result that is held back keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(front_value)
            && $stable(rear_value) && $stable(ok))
        else $error("stalled result changed");

    // One transaction in flight: the cycle after an accept the input is stalled.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // An empty queue reports both end values as all ones.
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == EMPTY_VALUE && rear_value == EMPTY_VALUE)
        else $error("empty queue reported end values");

    // When the input stall drops again just after the accept, the result is already shown.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 in_stall ##1 !in_stall |-> out_valid)
        else $error("request finished without a result");

endmodule

bind bounded_double_ended_queue_unit bdeq_checker u_bdeq_checker (.*);
